### hw/rtl/mfgd_pkg.sv
// ============================================================================
// mfgd_pkg
// Shared types, codes and helpers of the monochrome framebuffer glyph drawer.
// ============================================================================
`default_nettype none

package mfgd_pkg;

    // Byte index width: covers the largest buffer (8192 bytes) plus range checks
    localparam int FB_IDX_W = 14;

    // Command queue between front and back
    localparam int Q_DEPTH = 2;

    localparam logic [7:0] BYTE_WHITE = 8'hFF;
    localparam logic [7:0] BYTE_BLACK = 8'h00;
    localparam logic [7:0] MASK_TOP   = 8'h80;

    typedef enum logic [1:0] {
        CMD_PIXEL = 2'd0,
        CMD_GLYPH = 2'd1,
        CMD_FILL  = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_PIX_RD,
        ST_PIX_WR,
        ST_GLYPH,
        ST_GLYPH_END,
        ST_READ_RD,
        ST_READ_DATA,
        ST_DONE
    } t_state;

    // Classified command as it travels through the queue
    typedef struct packed {
        t_cmd                cmd;
        logic                ok;     // pixel on screen / read index in buffer
        logic [FB_IDX_W-1:0] idx;    // byte index for pixel and read
        logic [7:0]          mask;   // pixel bit mask
        logic                color;  // 1 black, 0 white
        logic [7:0]          x;
        logic [7:0]          y;
        logic [63:0]         bits;
    } t_work;

    // First byte of a screen column: (col * height) / 8
    function automatic logic [FB_IDX_W-1:0] col_base(input logic [7:0] col,
                                                      input int unsigned height);
        logic [16:0] prod;
        prod = 17'(col) * 17'(height);
        return prod[16:3];
    endfunction

endpackage

`default_nettype wire

### hw/rtl/mono_framebuffer_glyph_drawer_unit.sv
// ============================================================================
// mono_framebuffer_glyph_drawer_unit
// 1-bit-per-pixel column-major framebuffer with pixel, glyph, fill and read
// commands; a classifying front end feeds an executing back end via a queue.
// ============================================================================
//
//  channel  direction  handshake                  payload
//  -------  ---------  -------------------------  -------------------------------
//  in       input      i_in_valid / o_in_stall    command, x_pos, y_pos, color,
//                                                 glyph_bits, read_index
//  out      output     o_out_valid / i_out_stall  read_data (one per command)
//
//  In the back end a glyph runs sixteen byte read-modify-writes, one per
//  cycle through the RAM's read and write ports, and a fill writes one byte
//  per cycle.
//  After reset a clearing pass writes white over all FRAME_BYTES bytes (4096
//  by default) with o_in_stall held high.
//  The queue takes up to two commands while the back end works or while a
//  result waits on i_out_stall.
// ============================================================================
`default_nettype none

module mono_framebuffer_glyph_drawer_unit #(
    parameter int SCREEN_WIDTH  = 256,
    parameter int SCREEN_HEIGHT = 128
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_command,
    input  wire logic [7:0]  i_x_pos,
    input  wire logic [7:0]  i_y_pos,
    input  wire logic        i_color,
    input  wire logic [63:0] i_glyph_bits,
    input  wire logic [11:0] i_read_index,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_read_data
);

    import mfgd_pkg::*;

    t_work  push_data;
    t_work  pop_data;
    logic   q_push;
    logic   q_pop;
    logic   q_full;
    logic   q_empty;
    logic   clearing;

    mfgd_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_x_pos      (i_x_pos),
        .i_y_pos      (i_y_pos),
        .i_color      (i_color),
        .i_glyph_bits (i_glyph_bits),
        .i_read_index (i_read_index),
        .i_q_full     (q_full),
        .i_clearing   (clearing),
        .o_q_push     (q_push),
        .o_q_data     (push_data)
    );

    mfgd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (push_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (pop_data),
        .o_empty (q_empty)
    );

    mfgd_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_data    (pop_data),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .o_clearing  (clearing),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_read_data (o_read_data)
    );

    // No transaction enters during the post-reset clearing pass
    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !q_push)
        else $error("command accepted during clearing pass");

    // Back end only takes a command that the queue holds
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    // Queue never written past its depth
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("queue pushed while full");

    // A full queue stays full until the back end drains an entry
    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full && !q_pop |=> q_full)
        else $error("queue lost an entry without a pop");

endmodule

`default_nettype wire

### hw/rtl/mfgd_ram.sv
// ============================================================================
// mfgd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
`default_nettype none

module mfgd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write when enabled, read every cycle; read returns the old word on a collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hw/rtl/mfgd_front.sv
// ============================================================================
// mfgd_front
// Input side: takes command transactions, range checks and classifies them,
// computes pixel byte index and mask, and pushes them into the queue.
// ============================================================================
`default_nettype none

module mfgd_front #(
    parameter int SCREEN_WIDTH  = 256,
    parameter int SCREEN_HEIGHT = 128
) (
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_command,
    input  wire logic [7:0]         i_x_pos,
    input  wire logic [7:0]         i_y_pos,
    input  wire logic               i_color,
    input  wire logic [63:0]        i_glyph_bits,
    input  wire logic [11:0]        i_read_index,
    input  wire logic               i_q_full,
    input  wire logic               i_clearing,
    output logic                    o_q_push,
    output mfgd_pkg::t_work         o_q_data
);

    import mfgd_pkg::*;

    localparam int FRAME_BYTES = (SCREEN_WIDTH * SCREEN_HEIGHT) / 8;

    logic [FB_IDX_W-1:0] pix_idx;
    logic                pix_ok;
    logic                rd_ok;
    t_work               work;

    // Pixel address and on-screen check
    always_comb begin
        pix_idx = col_base(i_x_pos, SCREEN_HEIGHT) + FB_IDX_W'(i_y_pos[7:3]);
        pix_ok  = ({1'b0, i_x_pos} < 9'(SCREEN_WIDTH)) &&
                  ({1'b0, i_y_pos} < 9'(SCREEN_HEIGHT)) &&
                  (pix_idx < FB_IDX_W'(FRAME_BYTES));
        rd_ok   = FB_IDX_W'(i_read_index) < FB_IDX_W'(FRAME_BYTES);
    end

    // Classify the command
    always_comb begin
        work.cmd   = t_cmd'(i_command);
        work.x     = i_x_pos;
        work.y     = i_y_pos;
        work.color = i_color;
        work.bits  = i_glyph_bits;
        work.mask  = MASK_TOP >> i_y_pos[2:0];
        unique case (work.cmd) inside
            CMD_PIXEL: begin
                work.idx = pix_idx;
                work.ok  = pix_ok;
            end
            CMD_READ: begin
                work.idx = FB_IDX_W'(i_read_index);
                work.ok  = rd_ok;
            end
            CMD_GLYPH, CMD_FILL: begin
                work.idx = '0;
                work.ok  = 1'b0;
            end
            default: begin
                work.idx = '0;
                work.ok  = 1'b0;
            end
        endcase
    end

    // Hold off while the queue is full or the buffer is being cleared
    assign o_in_stall = i_q_full || i_clearing;
    assign o_q_push   = i_in_valid && !o_in_stall;
    assign o_q_data   = work;

endmodule

`default_nettype wire

### hw/rtl/mfgd_queue.sv
// ============================================================================
// mfgd_queue
// Short FIFO of classified commands between front and back.
// ============================================================================
`default_nettype none

module mfgd_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire mfgd_pkg::t_work i_data,
    output logic                 o_full,
    input  wire logic            i_pop,
    output mfgd_pkg::t_work      o_data,
    output logic                 o_empty
);

    import mfgd_pkg::*;

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_work          r_slot [Q_DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;

    assign o_full  = r_count == CW'(Q_DEPTH);
    assign o_empty = r_count == '0;
    assign o_data  = r_slot[r_rd_ptr];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/mfgd_back.sv
// ============================================================================
// mfgd_back
// Execution side: owns the framebuffer RAM, runs the clearing sweep, pixel and
// glyph read-modify-write, fill and read, and holds the result register.
// ============================================================================
`default_nettype none

module mfgd_back #(
    parameter int SCREEN_WIDTH  = 256,
    parameter int SCREEN_HEIGHT = 128
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire mfgd_pkg::t_work i_q_data,
    input  wire logic            i_q_empty,
    output logic                 o_q_pop,
    output logic                 o_clearing,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output logic [7:0]           o_read_data
);

    import mfgd_pkg::*;

    localparam int FRAME_BYTES = (SCREEN_WIDTH * SCREEN_HEIGHT) / 8;
    localparam int FB_AW       = $clog2(FRAME_BYTES);

    t_state              r_state, n_state;
    t_work               r_work;
    logic [3:0]          r_step;
    logic [FB_AW-1:0]    r_sweep;
    logic [7:0]          r_sweep_val;
    logic                r_sweep_res;
    logic                r_pend_we;
    logic [FB_AW-1:0]    r_pend_addr;
    logic [7:0]          r_pend_mask;
    logic [7:0]          r_pend_val;
    logic                r_fwd_hit;
    logic [7:0]          r_fwd_data;
    logic [7:0]          r_result;
    logic                r_out_valid;
    logic [7:0]          r_out_data;

    logic                sweep_last;
    logic                out_free;
    logic                q_pop;
    logic                load_out;
    logic                issue;
    logic                iss_we;
    logic [7:0]          iss_mask;
    logic [7:0]          iss_val;
    logic [FB_AW-1:0]    rd_addr;
    logic                ram_we;
    logic [FB_AW-1:0]    ram_waddr;
    logic [7:0]          ram_wdata;
    logic [7:0]          ram_rdata;
    logic [7:0]          rd_eff;

    logic [7:0]          gl_col;
    logic [4:0]          gl_slot_y;
    logic [FB_IDX_W-1:0] gl_idx;
    logic [7:0]          gl_mask;
    logic [7:0]          gl_val;
    logic                gl_ok;

    mfgd_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    assign sweep_last = r_sweep == FB_AW'(FRAME_BYTES - 1);
    assign out_free   = !r_out_valid || !i_out_stall;
    // Read data with bypass of a write to the same byte in the read cycle
    assign rd_eff     = r_fwd_hit ? r_fwd_data : ram_rdata;

    // Glyph step: column x+step/2, byte slot step%2 (top or next byte)
    always_comb begin
        logic [7:0] yy;
        logic [7:0] row_byte;
        gl_col    = r_work.x + {5'b0, r_step[3:1]};
        gl_slot_y = r_work.y[7:3] + {4'b0, r_step[0]};
        gl_idx    = col_base(gl_col, SCREEN_HEIGHT) + FB_IDX_W'(gl_slot_y);
        gl_mask   = '0;
        gl_val    = '0;
        for (int r = 0; r < 8; r++) begin
            yy       = r_work.y + 8'(r);
            row_byte = r_work.bits[8*(7-r) +: 8];
            if ((yy[7:3] == gl_slot_y) && ({1'b0, yy} < 9'(SCREEN_HEIGHT))) begin
                gl_mask[~yy[2:0]] = 1'b1;
                gl_val[~yy[2:0]]  = ~row_byte[r_step[3:1]];
            end
        end
        gl_ok = ({1'b0, gl_col} < 9'(SCREEN_WIDTH)) &&
                (gl_idx < FB_IDX_W'(FRAME_BYTES)) && (gl_mask != '0);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_SWEEP: begin
                if (sweep_last) begin
                    n_state = r_sweep_res ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!i_q_empty) begin
                    unique case (i_q_data.cmd)
                        CMD_PIXEL: n_state = ST_PIX_RD;
                        CMD_GLYPH: n_state = ST_GLYPH;
                        CMD_FILL:  n_state = ST_SWEEP;
                        CMD_READ:  n_state = ST_READ_RD;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_PIX_RD:    n_state = ST_PIX_WR;
            ST_PIX_WR:    n_state = ST_DONE;
            ST_GLYPH: begin
                if (r_step == 4'hF) begin
                    n_state = ST_GLYPH_END;
                end
            end
            ST_GLYPH_END: n_state = ST_DONE;
            ST_READ_RD:   n_state = ST_READ_DATA;
            ST_READ_DATA: n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    // State outputs: queue pop, RAM read issue, result load
    always_comb begin
        q_pop    = 1'b0;
        load_out = 1'b0;
        issue    = 1'b0;
        iss_we   = 1'b0;
        iss_mask = '0;
        iss_val  = '0;
        rd_addr  = r_work.idx[FB_AW-1:0];
        unique case (r_state)
            ST_IDLE:  q_pop = !i_q_empty;
            ST_PIX_RD: begin
                issue    = 1'b1;
                iss_we   = r_work.ok;
                iss_mask = r_work.mask;
                iss_val  = r_work.color ? BYTE_BLACK : BYTE_WHITE;
            end
            ST_GLYPH: begin
                issue    = 1'b1;
                iss_we   = gl_ok;
                iss_mask = gl_mask;
                iss_val  = gl_val;
                rd_addr  = gl_idx[FB_AW-1:0];
            end
            ST_DONE:  load_out = out_free;
            default: begin
            end
        endcase
    end

    // Write port: sweep or merge of the pending read-modify-write
    always_comb begin
        if (r_state == ST_SWEEP) begin
            ram_we    = 1'b1;
            ram_waddr = r_sweep;
            ram_wdata = r_sweep_val;
        end else begin
            ram_we    = r_pend_we;
            ram_waddr = r_pend_addr;
            ram_wdata = (rd_eff & ~r_pend_mask) | (r_pend_val & r_pend_mask);
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SWEEP;
            r_sweep     <= '0;
            r_sweep_val <= BYTE_WHITE;
            r_sweep_res <= 1'b0;
            r_step      <= '0;
            r_pend_we   <= 1'b0;
            r_fwd_hit   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pend_we <= issue && iss_we;
            r_fwd_hit <= ram_we && (ram_waddr == rd_addr);
            if (r_state == ST_SWEEP) begin
                r_sweep <= r_sweep + 1'b1;
            end
            if (q_pop) begin
                r_step      <= '0;
                r_sweep     <= '0;
                r_sweep_res <= 1'b1;
                r_sweep_val <= i_q_data.color ? BYTE_BLACK : BYTE_WHITE;
            end else if (r_state == ST_GLYPH) begin
                r_step <= r_step + 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_fwd_data <= ram_wdata;
        if (issue) begin
            r_pend_addr <= rd_addr;
            r_pend_mask <= iss_mask;
            r_pend_val  <= iss_val;
        end
        if (q_pop) begin
            r_work   <= i_q_data;
            r_result <= '0;
        end else if (r_state == ST_READ_DATA) begin
            r_result <= r_work.ok ? rd_eff : '0;
        end
        if (load_out) begin
            r_out_data <= r_result;
        end
    end

    assign o_q_pop     = q_pop;
    assign o_clearing  = (r_state == ST_SWEEP) && !r_sweep_res;
    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;

endmodule

`default_nettype wire

### tb/tb_mono_framebuffer_glyph_drawer_unit.sv
// ============================================================================
// tb_mono_framebuffer_glyph_drawer_unit
// Self-checking bench for the framebuffer glyph drawer. A directed run of
// pixel, glyph, fill and read commands is followed by random command streams
// under four idling profiles. A behavioral frame image predicts each
// read_data result, and the monitor checks it against the DUT output.
// ============================================================================
`default_nettype none

module tb_mono_framebuffer_glyph_drawer_unit;

    import mfgd_pkg::*;

    localparam int SCR_W          = 256;
    localparam int SCR_H          = 128;
    localparam int COL_BYTES      = SCR_H / 8;
    localparam int FB_BYTES       = SCR_W * SCR_H / 8;
    localparam int ITEMS_PER_PASS = 400;
    localparam int HOLD_CYCLES    = 400;
    localparam int QUIET_LIMIT    = 40000;

    // One drawing command as the sender presents it
    typedef struct {
        t_cmd        cmd;
        logic [7:0]  x;
        logic [7:0]  y;
        logic        color;
        logic [63:0] bits;
        logic [11:0] ridx;
    } t_draw_req;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic [1:0]  in_command   = '0;
    logic [7:0]  in_x_pos     = '0;
    logic [7:0]  in_y_pos     = '0;
    logic        in_color     = 1'b0;
    logic [63:0] in_glyph     = '0;
    logic [11:0] in_read_idx  = '0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [7:0]  out_read_data;

    // Frame image, pending commands and expected read bytes
    logic [7:0]  frame_image [FB_BYTES];
    t_draw_req   pending_cmds [$];
    logic [7:0]  expected_bytes [$];

    t_draw_req   drive_req;
    t_draw_req   seen_req;
    logic [7:0]  want_byte;
    logic        in_taken     = 1'b0;
    logic        out_taken    = 1'b0;
    int          err_count    = 0;
    int          quiet_cycles = 0;
    int          send_idle_pct  = 0;
    int          stall_pct      = 0;
    logic        hold_pending = 1'b0;
    int          hold_left    = 0;
    int          hot_x        = 0;
    int          hot_y        = 0;
    int          pass_idx;

    mono_framebuffer_glyph_drawer_unit i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_command    (in_command),
        .i_x_pos      (in_x_pos),
        .i_y_pos      (in_y_pos),
        .i_color      (in_color),
        .i_glyph_bits (in_glyph),
        .i_read_index (in_read_idx),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_read_data  (out_read_data)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Frame prediction
    // ------------------------------------------------------------------------

    // Off-screen pixels leave the image untouched
    function automatic void plot_pixel(input logic [7:0] px, input logic [7:0] py,
                                       input logic black);
        int         idx;
        logic [7:0] mask;
        if (int'(px) >= SCR_W || int'(py) >= SCR_H)
            return;
        idx  = int'(px) * COL_BYTES + int'(py) / 8;
        mask = MASK_TOP >> py[2:0];
        if (black)
            frame_image[idx] = frame_image[idx] & ~mask;
        else
            frame_image[idx] = frame_image[idx] | mask;
    endfunction

    // Updates the image for one command; returns the byte it reads out
    function automatic logic [7:0] run_draw_cmd(input t_draw_req req);
        logic [7:0] row;
        logic [7:0] data;
        data = '0;
        case (req.cmd)
            CMD_PIXEL: plot_pixel(req.x, req.y, req.color);
            CMD_GLYPH: begin
                // row byte 7-r lands on screen row y+r; color is ignored
                for (int r = 0; r < 8; r++) begin
                    row = req.bits[8*(7-r) +: 8];
                    for (int c = 0; c < 8; c++)
                        plot_pixel(req.x + 8'(c), req.y + 8'(r), row[c]);
                end
            end
            CMD_FILL: begin
                foreach (frame_image[i])
                    frame_image[i] = req.color ? BYTE_BLACK : BYTE_WHITE;
            end
            default: begin
                if (int'(req.ridx) < FB_BYTES)
                    data = frame_image[req.ridx];
            end
        endcase
        return data;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic void queue_cmd(input t_cmd cmd, input logic [7:0] x,
                                      input logic [7:0] y, input logic color,
                                      input logic [63:0] bits, input logic [11:0] ridx);
        t_draw_req req;
        req.cmd   = cmd;
        req.x     = x;
        req.y     = y;
        req.color = color;
        req.bits  = bits;
        req.ridx  = ridx;
        pending_cmds.push_back(req);
    endfunction

    // Mostly on-screen drawing, with reads aimed at recently drawn bytes
    function automatic t_draw_req random_cmd();
        t_draw_req   req;
        int unsigned pick;
        req.x     = 8'($urandom);
        req.y     = 8'($urandom);
        req.color = 1'($urandom);
        req.bits  = {$urandom, $urandom};
        req.ridx  = 12'($urandom);
        pick      = $urandom_range(999);
        if (pick < 10)
            req.cmd = CMD_FILL;
        else if (pick < 360)
            req.cmd = CMD_PIXEL;
        else if (pick < 620)
            req.cmd = CMD_GLYPH;
        else
            req.cmd = CMD_READ;
        case (req.cmd)
            CMD_PIXEL: begin
                if ($urandom_range(9) < 8)
                    req.y = 8'($urandom_range(SCR_H - 1));
                hot_x = req.x;
                hot_y = req.y;
            end
            CMD_GLYPH: begin
                if ($urandom_range(9) < 8)
                    req.y = 8'($urandom_range(SCR_H - 8));
                if ($urandom_range(9) == 0)
                    req.bits = $urandom_range(1) ? '1 : '0;
                hot_x = req.x;
                hot_y = req.y;
            end
            CMD_READ: begin
                if ($urandom_range(9) < 6)
                    req.ridx = 12'(hot_x * COL_BYTES + hot_y / 8 + $urandom_range(1));
            end
            default: ;
        endcase
        return req;
    endfunction

    // Waits until every command went in and every result came back
    task automatic wait_drained();
        while (pending_cmds.size() != 0 || in_valid || expected_bytes.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Sender: one command transaction per accept, random gaps
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        if (rst_n && (!in_valid || in_taken)) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                drive_req = pending_cmds.pop_front();
                in_valid    <= 1'b1;
                in_command  <= drive_req.cmd;
                in_x_pos    <= drive_req.x;
                in_y_pos    <= drive_req.y;
                in_color    <= drive_req.color;
                in_glyph    <= drive_req.bits;
                in_read_idx <= drive_req.ridx;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall, plus one long hold-off on request
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        if (hold_pending) begin
            hold_left    = HOLD_CYCLES;
            hold_pending = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on input accept, check on output accept, watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        in_taken  = rst_n && in_valid && !in_stall;
        out_taken = rst_n && out_valid && !out_stall;
        if (in_taken) begin
            seen_req.cmd   = t_cmd'(in_command);
            seen_req.x     = in_x_pos;
            seen_req.y     = in_y_pos;
            seen_req.color = in_color;
            seen_req.bits  = in_glyph;
            seen_req.ridx  = in_read_idx;
            expected_bytes.push_back(run_draw_cmd(seen_req));
        end
        if (out_taken) begin
            if (expected_bytes.size() == 0) begin
                err_count++;
                $display("%0t: unexpected result, expected none, got read_data %02h",
                         $time, out_read_data);
            end else begin
                want_byte = expected_bytes.pop_front();
                if (out_read_data !== want_byte) begin
                    err_count++;
                    $display("%0t: read_data mismatch, expected %02h, got %02h",
                             $time, want_byte, out_read_data);
                end
            end
        end
        if (!rst_n || in_taken || out_taken)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        foreach (frame_image[i])
            frame_image[i] = BYTE_WHITE;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: corners, dropped pixels, glyph wrap, fills
        queue_cmd(CMD_READ,  8'd0,   8'd0,   1'b0, '0, 12'd0);
        queue_cmd(CMD_READ,  8'd0,   8'd0,   1'b0, '0, 12'd4095);
        queue_cmd(CMD_PIXEL, 8'd0,   8'd0,   1'b1, '0, 12'd0);
        queue_cmd(CMD_READ,  8'd0,   8'd0,   1'b0, '0, 12'd0);
        queue_cmd(CMD_PIXEL, 8'd255, 8'd127, 1'b1, '1, 12'hFFF);
        queue_cmd(CMD_READ,  8'd0,   8'd0,   1'b0, '0, 12'd4095);
        queue_cmd(CMD_PIXEL, 8'd10,  8'd128, 1'b1, '0, 12'd0);
        queue_cmd(CMD_PIXEL, 8'd10,  8'd255, 1'b1, '0, 12'd0);
        queue_cmd(CMD_READ,  8'd0,   8'd0,   1'b0, '0, 12'd175);
        queue_cmd(CMD_PIXEL, 8'd0,   8'd0,   1'b0, '0, 12'd0);
        queue_cmd(CMD_READ,  8'd0,   8'd0,   1'b0, '0, 12'd0);
        queue_cmd(CMD_GLYPH, 8'd0,   8'd0,   1'b1, 64'h0123_4567_89AB_CDEF, 12'd0);
        queue_cmd(CMD_READ,  8'd0,   8'd0,   1'b0, '0, 12'd0);
        queue_cmd(CMD_READ,  8'd0,   8'd0,   1'b0, '0, 12'd16);
        // wraps in x to columns 0..3, lower half of the glyph falls off screen
        queue_cmd(CMD_GLYPH, 8'd252, 8'd124, 1'b0, '1, 12'd0);
        queue_cmd(CMD_READ,  8'd0,   8'd0,   1'b0, '0, 12'd4047);
        queue_cmd(CMD_READ,  8'd0,   8'd0,   1'b0, '0, 12'd15);
        // wraps in y: only the last two glyph rows reach rows 0 and 1
        queue_cmd(CMD_GLYPH, 8'd100, 8'd250, 1'b1, 64'hA55A_F00F_3CC3_8118, 12'd0);
        queue_cmd(CMD_READ,  8'd0,   8'd0,   1'b0, '0, 12'd1600);
        queue_cmd(CMD_FILL,  8'd0,   8'd0,   1'b1, '0, 12'd0);
        queue_cmd(CMD_READ,  8'd0,   8'd0,   1'b0, '0, 12'd2048);
        queue_cmd(CMD_PIXEL, 8'd3,   8'd9,   1'b0, '0, 12'd0);
        queue_cmd(CMD_READ,  8'd0,   8'd0,   1'b0, '0, 12'd49);
        queue_cmd(CMD_FILL,  8'd0,   8'd0,   1'b0, '0, 12'd0);
        queue_cmd(CMD_READ,  8'd0,   8'd0,   1'b0, '0, 12'd49);
        wait_drained();

        // Random passes: none, sender idle, receiver stall, both
        for (pass_idx = 0; pass_idx < 4; pass_idx++) begin
            case (pass_idx)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 78; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 78; end
                default: begin send_idle_pct = 36; stall_pct = 36; end
            endcase
            // long receiver hold-off while the sender keeps pushing
            if (pass_idx == 0)
                hold_pending = 1'b1;
            repeat (ITEMS_PER_PASS)
                pending_cmds.push_back(random_cmd());
            wait_drained();
        end

        repeat (30) @(posedge clk);
        if (expected_bytes.size() != 0) begin
            err_count++;
            $display("%0t: %0d results never arrived", $time, expected_bytes.size());
        end
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
hw/rtl/mfgd_pkg.sv
hw/rtl/mfgd_ram.sv
hw/rtl/mfgd_front.sv
hw/rtl/mfgd_queue.sv
hw/rtl/mfgd_back.sv
hw/rtl/mono_framebuffer_glyph_drawer_unit.sv
tb/tb_mono_framebuffer_glyph_drawer_unit.sv
